[src/deadline_ordered_timer_queue_top_assert.svh]
// Assertion macros for the deadline-ordered timer queue.
// Expects clk_i and rst_ni in the scope of use.
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_TOP_ASSERT_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define DOTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DOTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dotq_pkg.sv]
// Package for the deadline-ordered timer queue: depth, widths, codes and item types.
// No dependencies.
`default_nettype none

package dotq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TICK_W      = 48;
  localparam int unsigned DELAY_W     = 24;
  localparam int unsigned TASK_W      = 16;
  localparam int unsigned PEND_W      = 5;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SCHED   = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [DELAY_W-1:0] delay;
    logic [TASK_W-1:0]  task_id;
  } dotq_cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TASK_W-1:0] due_task;
    logic [PEND_W-1:0] pending_count;
  } dotq_res_t;

  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [TASK_W-1:0] task_id;
  } dotq_entry_t;

endpackage

`default_nettype wire

[src/deadline_ordered_timer_queue_top.sv]
// Deadline-ordered timer queue: tick counter plus a sorted entry memory.
// Depends on dotq_pkg and deadline_ordered_timer_queue_top_assert.svh.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------
//   command   | start, busy          | cmd_i  (operation, delay, task_id)
//   result    | res_valid_o (strobe) | result_o (status, due_task, pending_count)
//
// Tick, unused code, full or empty cases: result strobe in the cycle after start.
// Schedule shifts later entries up from the tail; consume shifts the rest down.
// Both walk the entry memory one entry per cycle through a single read and
// write port and one shared 48-bit comparator.
// rst_ni clears the counter and the fill count; the memory needs no clearing.
// A new item may start in the cycle the previous result is strobed.
`default_nettype none

module deadline_ordered_timer_queue_top
  import dotq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire dotq_cmd_t cmd_i,
  output logic           res_valid_o,
  output dotq_res_t      result_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCH  = 3'd1;
  localparam logic [2:0] ST_INS  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_SHF  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [TICK_W-1:0] now_q, now_d;
  logic [TICK_W-1:0] due_q, due_d;
  logic [TASK_W-1:0] ntask_q, ntask_d;
  logic [TASK_W-1:0] pop_q, pop_d;
  logic [IDX_W-1:0]  k_q, k_d;
  dotq_res_t         res_q, res_d;
  logic              res_valid_q, res_valid_d;

  dotq_entry_t       mem [QUEUE_DEPTH];
  dotq_entry_t       rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  dotq_entry_t       wdata;

  logic [CNT_W-1:0]  cnt_m1;
  logic [TICK_W:0]   sum;
  logic [TICK_W-1:0] due_calc;
  logic [TICK_W-1:0] cmp_a, cmp_b;
  logic              lt;
  logic              finish;
  logic [1:0]        stat_v;
  logic [TASK_W-1:0] task_v;

  assign cnt_m1   = count_q - CNT_W'(1);
  assign sum      = {1'b0, now_q} + (TICK_W+1)'(cmd_i.delay);
  assign due_calc = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];

  assign cmp_a = (state_q == ST_CHK) ? now_q : rd_q.deadline;
  assign cmp_b = (state_q == ST_CHK) ? rd_q.deadline : due_q;
  assign lt    = cmp_a < cmp_b;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    now_d    = now_q;
    due_d    = due_q;
    ntask_d  = ntask_q;
    pop_d    = pop_q;
    k_d      = k_q;
    rd_addr  = k_q;
    we       = 1'b0;
    waddr    = k_q;
    wdata    = rd_q;
    finish   = 1'b0;
    stat_v   = STAT_OK;
    task_v   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_i.operation)
            OP_TICK: begin
              if (now_q != TICK_MAX) begin
                now_d = now_q + TICK_W'(1);
              end
              finish = 1'b1;
            end
            OP_SCHED: begin
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                stat_v = STAT_FULL;
                finish = 1'b1;
              end else if (count_q == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = '{deadline: due_calc, task_id: cmd_i.task_id};
                count_d = count_q + CNT_W'(1);
                finish  = 1'b1;
              end else begin
                due_d   = due_calc;
                ntask_d = cmd_i.task_id;
                k_d     = count_q[IDX_W-1:0];
                rd_addr = cnt_m1[IDX_W-1:0];
                state_d = ST_SCH;
              end
            end
            OP_CONSUME: begin
              if (count_q == '0) begin
                stat_v = STAT_NONE;
                finish = 1'b1;
              end else begin
                rd_addr = '0;
                state_d = ST_CHK;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_SCH: begin
        we = 1'b1;
        if (!lt) begin
          wdata = rd_q;
          if (k_q == IDX_W'(1)) begin
            k_d     = '0;
            state_d = ST_INS;
          end else begin
            k_d     = k_q - IDX_W'(1);
            rd_addr = k_q - IDX_W'(2);
          end
        end else begin
          wdata   = '{deadline: due_q, task_id: ntask_q};
          count_d = count_q + CNT_W'(1);
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_INS: begin
        we      = 1'b1;
        wdata   = '{deadline: due_q, task_id: ntask_q};
        count_d = count_q + CNT_W'(1);
        finish  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_CHK: begin
        if (lt) begin
          stat_v  = STAT_NONE;
          finish  = 1'b1;
          state_d = ST_IDLE;
        end else if (count_q == CNT_W'(1)) begin
          count_d = '0;
          task_v  = rd_q.task_id;
          finish  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          pop_d   = rd_q.task_id;
          k_d     = IDX_W'(1);
          rd_addr = IDX_W'(1);
          state_d = ST_SHF;
        end
      end
      ST_SHF: begin
        we    = 1'b1;
        waddr = k_q - IDX_W'(1);
        wdata = rd_q;
        if (k_q == cnt_m1[IDX_W-1:0]) begin
          count_d = cnt_m1;
          task_v  = pop_q;
          finish  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          k_d     = k_q + IDX_W'(1);
          rd_addr = k_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    res_valid_d = finish;
    res_d       = res_q;
    if (finish) begin
      res_d = '{status: stat_v, due_task: task_v, pending_count: PEND_W'(count_d)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      now_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      now_q       <= now_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    due_q   <= due_d;
    ntask_q <= ntask_d;
    pop_q   <= pop_d;
    k_q     <= k_d;
    res_q   <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign result_o    = res_q;

`include "deadline_ordered_timer_queue_top_assert.svh"

  `DOTQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "fill count overflow")
  `DOTQ_ASSERT_NEXT(a_start_resp, start && !busy, busy || res_valid_o, "item accepted but dropped")
  `DOTQ_ASSERT_NOW(a_full_stat, res_valid_o && (result_o.status == STAT_FULL),
                   count_q == CNT_W'(QUEUE_DEPTH), "full status with free entries")
  `DOTQ_ASSERT_NOW(a_task_zero, res_valid_o && (result_o.status != STAT_OK),
                   result_o.due_task == '0, "task returned without a pop")

endmodule

`default_nettype wire
